// ===== hdl/oilp_pkg.sv =====
// ----------------------------------------------------------------------------
// oilp_pkg
// Types, constants and helpers shared by the oil-paint mode filter.
// ----------------------------------------------------------------------------
package oilp_pkg;

  localparam int GRAY_LEVELS = 256;
  localparam int GRAY_W      = 8;
  localparam int COL_W       = 12;
  localparam int ROW_W       = 10;
  localparam int HEIGHT_MAX  = 1024;
  localparam int RAD_W       = 3;
  localparam int SLOT_W      = 4;
  localparam int RESULT_CAP  = 64;
  localparam int CNT_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int JOBQ_DEPTH  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_e;

  // effective (clamped) frame settings
  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [COL_W:0]   width;
    logic [ROW_W:0]   height;
  } frame_cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
    logic [SLOT_W-1:0] slot;
    logic              last;
    logic              done;
  } job_t;

  typedef enum logic {
    F_IDLE,
    F_EMIT
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_FLUSH,
    B_HOLD
  } back_state_e;

  function automatic logic [GRAY_W-1:0] gray_of(input logic [31:0] p);
    logic [12:0] sum;
    sum = 13'(p[23:16]) * 13'd11 + 13'(p[15:8]) * 13'd16 + 13'(p[7:0]) * 13'd5;
    return sum[12:5];
  endfunction

  // last input position a window needs is at or before the arrived one
  function automatic logic need_ok(input logic [COL_W-1:0] x,
                                   input logic [ROW_W-1:0] y,
                                   input logic [RAD_W-1:0] r,
                                   input logic [COL_W:0]   wm1,
                                   input logic [ROW_W:0]   hm1,
                                   input logic [COL_W-1:0] ac,
                                   input logic [ROW_W-1:0] ar);
    logic [COL_W:0] cx;
    logic [ROW_W:0] ry;
    cx = {1'b0, x} + (COL_W+1)'(r);
    if (cx > wm1) cx = wm1;
    ry = {1'b0, y} + (ROW_W+1)'(r);
    if (ry > hm1) ry = hm1;
    return (ry < {1'b0, ar}) || ((ry == {1'b0, ar}) && (cx <= {1'b0, ac}));
  endfunction

endpackage

// ===== hdl/oilp_in_if.sv =====
// ----------------------------------------------------------------------------
// oilp_in_if
// Input pixel channel, valid/ready.
// ----------------------------------------------------------------------------
interface oilp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_argb;

  modport source (output valid, output pixel_argb, input ready);
  modport sink   (input valid, input pixel_argb, output ready);
endinterface

// ===== hdl/oilp_out_if.sv =====
// ----------------------------------------------------------------------------
// oilp_out_if
// Result pixel channel, valid/ready.
// ----------------------------------------------------------------------------
interface oilp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;
  logic        last_in_run;
  logic        frame_done;

  modport source (output valid, output out_pixel, output last_in_run, output frame_done,
                  input ready);
  modport sink   (input valid, input out_pixel, input last_in_run, input frame_done,
                  output ready);
endinterface

// ===== hdl/oilp_ram.sv =====
// ----------------------------------------------------------------------------
// oilp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module oilp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/oilp_job_fifo.sv =====
// ----------------------------------------------------------------------------
// oilp_job_fifo
// Short queue of output jobs between the front and back ends.
// ----------------------------------------------------------------------------
module oilp_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           flush_i,
  input  logic           push_i,
  input  oilp_pkg::job_t data_i,
  input  logic           pop_i,
  output oilp_pkg::job_t data_o,
  output logic           full_o,
  output logic           empty_o
);
  import oilp_pkg::*;

  localparam int PW = $clog2(JOBQ_DEPTH);

  job_t          mem_q [JOBQ_DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PW+1)'(JOBQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (flush_i) begin
      wp_d  = '0;
      rp_d  = '0;
      cnt_d = '0;
    end else begin
      if (push_i) wp_d = (wp_q == PW'(JOBQ_DEPTH-1)) ? '0 : wp_q + PW'(1);
      if (pop_i)  rp_d = (rp_q == PW'(JOBQ_DEPTH-1)) ? '0 : rp_q + PW'(1);
      if (push_i && !pop_i) cnt_d = cnt_q + (PW+1)'(1);
      if (!push_i && pop_i) cnt_d = cnt_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

// ===== hdl/oilp_front.sv =====
// ----------------------------------------------------------------------------
// oilp_front
// Takes input pixels into the line store and queues the outputs they release.
// ----------------------------------------------------------------------------
module oilp_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  oilp_in_if.sink                 pix,
  input  oilp_pkg::frame_cfg_t    cfg_i,
  input  logic                    restart_i,
  input  logic                    back_idle_i,
  input  logic                    q_full_i,
  input  logic                    q_empty_i,
  output logic                    push_o,
  output oilp_pkg::job_t          job_o,
  output logic                    ls_we_o,
  output logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH)-1:0] ls_waddr_o,
  output logic [31:0]             ls_wdata_o
);
  import oilp_pkg::*;

  localparam int ROW_SLOTS = 2*MAX_RADIUS + 1;
  localparam int LS_AW     = $clog2(ROW_SLOTS*MAX_WIDTH);

  front_state_e      state_q, state_d;
  logic [COL_W-1:0]  in_col_q, in_col_d, out_x_q, out_x_d, ar_col_q, ar_col_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d, out_y_q, out_y_d, ar_row_q, ar_row_d;
  logic [SLOT_W-1:0] in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic              in_done_q, in_done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic [COL_W:0]    w_m1;
  logic [ROW_W:0]    h_m1;
  logic              accept, x_last, is_done, q_cur, q_next;
  logic [COL_W-1:0]  nx;
  logic [ROW_W-1:0]  ny;
  logic [SLOT_W-1:0] nslot;

  assign w_m1   = cfg_i.width - (COL_W+1)'(1);
  assign h_m1   = cfg_i.height - (ROW_W+1)'(1);
  assign accept = pix.valid && pix.ready;

  assign x_last  = ({1'b0, out_x_q} == w_m1);
  assign is_done = x_last && ({1'b0, out_y_q} == h_m1);
  assign nx      = x_last ? '0 : out_x_q + COL_W'(1);
  assign ny      = x_last ? out_y_q + ROW_W'(1) : out_y_q;
  assign nslot   = !x_last ? out_slot_q :
                   (out_slot_q == SLOT_W'(ROW_SLOTS-1)) ? '0 : out_slot_q + SLOT_W'(1);

  assign q_cur  = (cnt_q < CNT_W'(RESULT_CAP)) &&
                  need_ok(out_x_q, out_y_q, cfg_i.radius, w_m1, h_m1, ar_col_q, ar_row_q);
  assign q_next = !is_done && ((cnt_q + CNT_W'(1)) < CNT_W'(RESULT_CAP)) &&
                  need_ok(nx, ny, cfg_i.radius, w_m1, h_m1, ar_col_q, ar_row_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (accept) state_d = F_EMIT;
      F_EMIT: begin
        if (!q_cur || (push_o && is_done)) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
    if (restart_i) state_d = F_IDLE;
  end

  // outputs
  always_comb begin
    pix.ready  = (state_q == F_IDLE) && q_empty_i && back_idle_i;
    push_o     = (state_q == F_EMIT) && q_cur && !q_full_i;
    job_o      = '{x: out_x_q, y: out_y_q, slot: out_slot_q, last: !q_next, done: is_done};
    ls_we_o    = accept && !in_done_q;
    ls_waddr_o = LS_AW'(in_slot_q) * LS_AW'(MAX_WIDTH) + LS_AW'(in_col_q);
    ls_wdata_o = pix.pixel_argb;
  end

  // positions
  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    in_done_d  = in_done_q;
    out_x_d    = out_x_q;
    out_y_d    = out_y_q;
    out_slot_d = out_slot_q;
    ar_col_d   = ar_col_q;
    ar_row_d   = ar_row_q;
    cnt_d      = cnt_q;
    if (restart_i) begin
      in_col_d   = '0;
      in_row_d   = '0;
      in_slot_d  = '0;
      in_done_d  = 1'b0;
      out_x_d    = '0;
      out_y_d    = '0;
      out_slot_d = '0;
    end else if (accept) begin
      cnt_d = '0;
      if (!in_done_q) begin
        ar_col_d = in_col_q;
        ar_row_d = in_row_q;
        if ({1'b0, in_col_q} == w_m1) begin
          in_col_d = '0;
          if ({1'b0, in_row_q} == h_m1) begin
            in_row_d  = '0;
            in_slot_d = '0;
            in_done_d = 1'b1;
          end else begin
            in_row_d  = in_row_q + ROW_W'(1);
            in_slot_d = (in_slot_q == SLOT_W'(ROW_SLOTS-1)) ? '0 : in_slot_q + SLOT_W'(1);
          end
        end else begin
          in_col_d = in_col_q + COL_W'(1);
        end
      end else begin
        ar_col_d = w_m1[COL_W-1:0];
        ar_row_d = h_m1[ROW_W-1:0];
      end
    end else if (push_o) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (is_done) begin
        out_x_d    = '0;
        out_y_d    = '0;
        out_slot_d = '0;
        in_done_d  = 1'b0;
      end else begin
        out_x_d    = nx;
        out_y_d    = ny;
        out_slot_d = nslot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      in_done_q  <= 1'b0;
      out_x_q    <= '0;
      out_y_q    <= '0;
      out_slot_q <= '0;
      ar_col_q   <= '0;
      ar_row_q   <= '0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      in_done_q  <= in_done_d;
      out_x_q    <= out_x_d;
      out_y_q    <= out_y_d;
      out_slot_q <= out_slot_d;
      ar_col_q   <= ar_col_d;
      ar_row_q   <= ar_row_d;
      cnt_q      <= cnt_d;
    end
  end

  a_done_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && job_o.done |-> in_done_q)
    else $error("frame done queued before whole frame arrived");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(RESULT_CAP))
    else $error("burst count above cap");

endmodule

// ===== hdl/oilp_back.sv =====
// ----------------------------------------------------------------------------
// oilp_back
// Scans one window per job, one pixel a cycle, through a histogram RAM.
// ----------------------------------------------------------------------------
module oilp_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  oilp_pkg::frame_cfg_t cfg_i,
  input  logic                 q_empty_i,
  input  oilp_pkg::job_t       q_data_i,
  output logic                 pop_o,
  output logic                 idle_o,
  output logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH)-1:0] ls_raddr_o,
  input  logic [31:0]          ls_rdata_i,
  oilp_out_if.source           res
);
  import oilp_pkg::*;

  localparam int ROW_SLOTS = 2*MAX_RADIUS + 1;
  localparam int LS_AW     = $clog2(ROW_SLOTS*MAX_WIDTH);

  back_state_e              state_q, state_d;
  logic [COL_W-1:0]         lo_q, lo_d, hi_q, hi_d, col_q, col_d;
  logic [SLOT_W-1:0]        j_q, j_d, jmax_q, jmax_d, slot_q, slot_d;
  logic signed [ROW_W+1:0]  craw_q, craw_d, craw_n;
  logic                     last_q, last_d, done_q, done_d;
  logic                     s1_v_q, s1_v_d, s2_v_q;
  logic [31:0]              s2_pix_q;
  logic [GRAY_W-1:0]        s2_g_q, fwd_val_q, best_q, best_d;
  logic                     fwd_hit_q;
  logic [GRAY_LEVELS-1:0]   hv_q, hv_d;
  logic [31:0]              chosen_q, chosen_d;
  logic                     out_v_q, out_v_d, load;
  logic [31:0]              out_pix_q;
  logic                     out_last_q, out_done_q;

  logic [COL_W:0]           w_m1, xr;
  logic [ROW_W:0]           h_m1;
  logic [GRAY_W-1:0]        g1, h_rdata, base, cnt_new;
  logic [SLOT_W:0]          st;
  logic                     issue_last;

  assign w_m1 = cfg_i.width - (COL_W+1)'(1);
  assign h_m1 = cfg_i.height - (ROW_W+1)'(1);

  // histogram pipeline
  assign g1      = gray_of(ls_rdata_i);
  assign base    = fwd_hit_q ? fwd_val_q : (hv_q[s2_g_q] ? h_rdata : '0);
  assign cnt_new = base + GRAY_W'(1);

  oilp_ram #(.WIDTH(GRAY_W), .DEPTH(GRAY_LEVELS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (s2_v_q),
    .waddr_i (s2_g_q),
    .wdata_i (cnt_new),
    .raddr_i (g1),
    .rdata_o (h_rdata)
  );

  assign craw_n     = craw_q + (ROW_W+2)'(1);
  assign issue_last = (col_q == hi_q) && (j_q == jmax_q);
  assign xr         = {1'b0, q_data_i.x} + (COL_W+1)'(cfg_i.radius);
  assign st         = (SLOT_W+1)'(q_data_i.slot) + (SLOT_W+1)'(ROW_SLOTS)
                      - (SLOT_W+1)'(cfg_i.radius);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (!q_empty_i) state_d = B_SCAN;
      B_SCAN:  if (issue_last) state_d = B_FLUSH;
      B_FLUSH: if (!s1_v_q && !s2_v_q) state_d = B_HOLD;
      B_HOLD:  if (!out_v_q || res.ready) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o           = (state_q == B_IDLE) && !q_empty_i;
    idle_o          = (state_q == B_IDLE);
    load            = (state_q == B_HOLD) && (!out_v_q || res.ready);
    ls_raddr_o      = LS_AW'(slot_q) * LS_AW'(MAX_WIDTH) + LS_AW'(col_q);
    res.valid       = out_v_q;
    res.out_pixel   = out_pix_q;
    res.last_in_run = out_last_q;
    res.frame_done  = out_done_q;
  end

  // scan control
  always_comb begin
    lo_d     = lo_q;
    hi_d     = hi_q;
    col_d    = col_q;
    j_d      = j_q;
    jmax_d   = jmax_q;
    slot_d   = slot_q;
    craw_d   = craw_q;
    last_d   = last_q;
    done_d   = done_q;
    hv_d     = hv_q;
    best_d   = best_q;
    chosen_d = chosen_q;
    s1_v_d   = 1'b0;
    out_v_d  = out_v_q;
    if (pop_o) begin
      lo_d   = (q_data_i.x >= COL_W'(cfg_i.radius)) ? q_data_i.x - COL_W'(cfg_i.radius) : '0;
      hi_d   = (xr > w_m1) ? w_m1[COL_W-1:0] : xr[COL_W-1:0];
      col_d  = lo_d;
      j_d    = '0;
      jmax_d = {cfg_i.radius, 1'b0};
      craw_d = $signed({2'b00, q_data_i.y}) - $signed((ROW_W+2)'(cfg_i.radius));
      if (q_data_i.y < ROW_W'(cfg_i.radius)) begin
        slot_d = '0;
      end else begin
        slot_d = (st >= (SLOT_W+1)'(ROW_SLOTS)) ? SLOT_W'(st - (SLOT_W+1)'(ROW_SLOTS))
                                                : SLOT_W'(st);
      end
      last_d   = q_data_i.last;
      done_d   = q_data_i.done;
      hv_d     = '0;
      best_d   = '0;
      chosen_d = '0;
    end
    if (state_q == B_SCAN) begin
      s1_v_d = 1'b1;
      if (col_q == hi_q) begin
        col_d  = lo_q;
        j_d    = j_q + SLOT_W'(1);
        craw_d = craw_n;
        if ((craw_n > 0) && (craw_n <= $signed({1'b0, h_m1}))) begin
          slot_d = (slot_q == SLOT_W'(ROW_SLOTS-1)) ? '0 : slot_q + SLOT_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
    if (s2_v_q) begin
      hv_d[s2_g_q] = 1'b1;
      if (cnt_new > best_q) begin
        best_d   = cnt_new;
        chosen_d = s2_pix_q;
      end
    end
    if (res.valid && res.ready) out_v_d = 1'b0;
    if (load) out_v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      hv_q    <= '0;
    end else begin
      state_q <= state_d;
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s1_v_q;
      out_v_q <= out_v_d;
      hv_q    <= hv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    col_q     <= col_d;
    j_q       <= j_d;
    jmax_q    <= jmax_d;
    slot_q    <= slot_d;
    craw_q    <= craw_d;
    last_q    <= last_d;
    done_q    <= done_d;
    best_q    <= best_d;
    chosen_q  <= chosen_d;
    s2_pix_q  <= ls_rdata_i;
    s2_g_q    <= g1;
    fwd_hit_q <= s2_v_q && (s2_g_q == g1);
    fwd_val_q <= cnt_new;
    if (load) begin
      out_pix_q  <= chosen_q;
      out_last_q <= last_q;
      out_done_q <= done_q;
    end
  end

  a_pipe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (state_q == B_SCAN || state_q == B_FLUSH))
    else $error("histogram update outside a scan");

  a_window_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_HOLD |-> best_q != '0)
    else $error("window finished with no pixel counted");

endmodule

// ===== hdl/oil_paint_mode_filter.sv =====
// ----------------------------------------------------------------------------
// oil_paint_mode_filter
// Oil-paint mode filter: each output pixel is the first window pixel whose
// gray-level count becomes the strict maximum of a (2r+1)-row window.
//
// An input pixel is taken only when the previous one's outputs have all been
// computed. Each output's window is scanned one pixel per cycle (rows times
// clipped columns, up to 225 at radius 7), set by the single line-store read
// port feeding the histogram read-modify-write pipeline; a drain and a hold
// state follow, the hold waiting while the previous result is not yet taken.
// Writes to the radius, width and height registers restart the frame.
// ----------------------------------------------------------------------------
module oil_paint_mode_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  oilp_in_if.sink                            pix_i,
  oilp_out_if.source                         res_o,
  input  logic                               cfg_we_i,
  input  logic [oilp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [oilp_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import oilp_pkg::*;

  localparam int ROW_SLOTS = 2*MAX_RADIUS + 1;
  localparam int LS_DEPTH  = ROW_SLOTS*MAX_WIDTH;
  localparam int LS_AW     = $clog2(LS_DEPTH);

  logic [RAD_W-1:0]      radius_q, radius_d;
  logic [CFG_DATA_W-1:0] width_q, width_d, height_q, height_d;
  logic                  restart;
  frame_cfg_t            cfg;

  logic                  push, pop, q_full, q_empty, back_idle, ls_we;
  job_t                  job_in, job_out;
  logic [LS_AW-1:0]      ls_waddr, ls_raddr;
  logic [31:0]           ls_wdata, ls_rdata;

  always_comb begin
    radius_d = radius_q;
    width_d  = width_q;
    height_d = height_q;
    restart  = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS: begin
          radius_d = cfg_data_i[RAD_W-1:0];
          restart  = 1'b1;
        end
        REG_WIDTH: begin
          width_d = cfg_data_i;
          restart = 1'b1;
        end
        REG_HEIGHT: begin
          height_d = cfg_data_i;
          restart  = 1'b1;
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_comb begin
    if (radius_q == '0)                         cfg.radius = RAD_W'(1);
    else if (radius_q > RAD_W'(MAX_RADIUS))     cfg.radius = RAD_W'(MAX_RADIUS);
    else                                        cfg.radius = radius_q;
    if (width_q == '0)                          cfg.width = (COL_W+1)'(1);
    else if ((COL_W+1)'(width_q) > (COL_W+1)'(MAX_WIDTH))
                                                cfg.width = (COL_W+1)'(MAX_WIDTH);
    else                                        cfg.width = (COL_W+1)'(width_q);
    if (height_q == '0)                         cfg.height = (ROW_W+1)'(1);
    else if (height_q > CFG_DATA_W'(HEIGHT_MAX)) cfg.height = (ROW_W+1)'(HEIGHT_MAX);
    else                                        cfg.height = (ROW_W+1)'(height_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RAD_W'(2);
      width_q  <= CFG_DATA_W'(640);
      height_q <= CFG_DATA_W'(480);
    end else begin
      radius_q <= radius_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  oilp_ram #(.WIDTH(32), .DEPTH(LS_DEPTH)) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (ls_waddr),
    .wdata_i (ls_wdata),
    .raddr_i (ls_raddr),
    .rdata_o (ls_rdata)
  );

  oilp_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix         (pix_i),
    .cfg_i       (cfg),
    .restart_i   (restart),
    .back_idle_i (back_idle),
    .q_full_i    (q_full),
    .q_empty_i   (q_empty),
    .push_o      (push),
    .job_o       (job_in),
    .ls_we_o     (ls_we),
    .ls_waddr_o  (ls_waddr),
    .ls_wdata_o  (ls_wdata)
  );

  oilp_job_fifo u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (restart),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .data_o  (job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  oilp_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_empty_i  (q_empty),
    .q_data_i   (job_out),
    .pop_o      (pop),
    .idle_o     (back_idle),
    .ls_raddr_o (ls_raddr),
    .ls_rdata_i (ls_rdata),
    .res        (res_o)
  );

  a_store_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ls_we |-> back_idle && q_empty)
    else $error("line store written while windows are pending");

endmodule

// ===== tb/oil_paint_mode_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oil_paint_mode_filter_tb
// Drives ARGB pixel frames into the oil-paint mode filter under several frame
// settings and random stalls on both channels. A local model of the window
// histogram predicts every result item, which is checked field by field.
// ----------------------------------------------------------------------------
module oil_paint_mode_filter_tb;
  import oilp_pkg::*;

  localparam int   STORE_COLS   = 1024;
  localparam int   STORE_ROWS   = 15;
  localparam int   BURST_CAP    = 64;
  localparam int   CYCLE_LIMIT  = 6000000;
  localparam int   SETTLE       = 300;
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG = 2'd3;

  typedef struct {
    logic [31:0] pixel;
    logic        last_in_run;
    logic        frame_done;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  oilp_in_if  pix ();
  oilp_out_if res ();

  oil_paint_mode_filter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix),
    .res_o      (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // model state
  logic [31:0] line_mem [STORE_ROWS*STORE_COLS];
  int          gray_cnt [GRAY_LEVELS];
  int unsigned col_in, row_in, out_pos;
  bit          frame_in_done;
  logic [2:0]  tb_radius;
  logic [10:0] m_width, m_height;
  result_t     pending_q [$];

  int errors = 0;
  int send_pct = 0;
  int recv_pct = 0;
  int hold_cycles = 0;
  int unsigned cycles = 0;
  logic [31:0] palette [4];

  function automatic int eff_radius();
    int r;
    r = (tb_radius == 0) ? 1 : tb_radius;
    return r;
  endfunction

  function automatic int eff_width();
    int w;
    w = (m_width == 0) ? 1 : m_width;
    if (w > STORE_COLS) w = STORE_COLS;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = (m_height == 0) ? 1 : m_height;
    if (h > HEIGHT_MAX) h = HEIGHT_MAX;
    return h;
  endfunction

  function automatic int gray_level(logic [31:0] p);
    return (p[23:16] * 11 + p[15:8] * 16 + p[7:0] * 5) >> 5;
  endfunction

  function automatic logic [31:0] pick_mode_pixel(int y, int x, int r, int w, int h);
    int lo, hi, row, best, c, g;
    logic [31:0] p, chosen;
    lo = (x - r < 0) ? 0 : x - r;
    hi = (x + r > w - 1) ? w - 1 : x + r;
    best = 0;
    chosen = '0;
    for (int k = 0; k < GRAY_LEVELS; k++) gray_cnt[k] = 0;
    for (int j = 0; j <= 2 * r; j++) begin
      row = y - r + j;
      if (row < 0) row = 0;
      if (row > h - 1) row = h - 1;
      for (int i = lo; i <= hi; i++) begin
        p = line_mem[(row % STORE_ROWS) * STORE_COLS + i];
        g = gray_level(p);
        c = (gray_cnt[g] + 1) & 8'hFF;
        gray_cnt[g] = c;
        if (c > best) begin
          best = c;
          chosen = p;
        end
      end
    end
    return chosen;
  endfunction

  function automatic void restart_frame();
    col_in = 0;
    row_in = 0;
    out_pos = 0;
    frame_in_done = 0;
  endfunction

  function automatic void predict_outputs(logic [31:0] p);
    int r, w, h, n, y, x, ry, cx;
    int unsigned total, arrived, need;
    result_t e;
    r = eff_radius();
    w = eff_width();
    h = eff_height();
    total = w * h;
    n = 0;
    if (!frame_in_done) begin
      if (col_in >= w) col_in = 0;
      if (row_in >= h) row_in = 0;
      line_mem[(row_in % STORE_ROWS) * STORE_COLS + col_in] = p;
      arrived = row_in * w + col_in;
      col_in++;
      if (col_in == w) begin
        col_in = 0;
        row_in++;
        if (row_in == h) begin
          row_in = 0;
          frame_in_done = 1;
        end
      end
    end else begin
      arrived = total - 1;
    end
    while (n < BURST_CAP && out_pos < total) begin
      y = out_pos / w;
      x = out_pos % w;
      ry = (y + r > h - 1) ? h - 1 : y + r;
      cx = (x + r > w - 1) ? w - 1 : x + r;
      need = ry * w + cx;
      if (need > arrived) break;
      e.pixel = pick_mode_pixel(y, x, r, w, h);
      e.last_in_run = 1'b0;
      e.frame_done = (out_pos == total - 1);
      pending_q.push_back(e);
      out_pos++;
      n++;
    end
    if (n > 0) pending_q[pending_q.size()-1].last_in_run = 1'b1;
    if (frame_in_done && out_pos >= total) restart_frame();
  endfunction

  // result checker
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item: pixel %h", res.out_pixel);
      end else begin
        e = pending_q.pop_front();
        if (res.out_pixel !== e.pixel || res.last_in_run !== e.last_in_run ||
            res.frame_done !== e.frame_done) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp pixel %h last %b done %b, got pixel %h last %b done %b",
                     e.pixel, e.last_in_run, e.frame_done,
                     res.out_pixel, res.last_in_run, res.frame_done);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= recv_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // all tasks start and end at a falling edge
  task automatic send_pixel(logic [31:0] p);
    while ($urandom_range(0, 99) < send_pct) begin
      pix.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.pixel_argb <= p;
    do @(posedge clk_i); while (!pix.ready);
    predict_outputs(p);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    pix.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_RADIUS) begin
      tb_radius = val[2:0];
      restart_frame();
    end else if (idx == REG_WIDTH) begin
      m_width = val[10:0];
      restart_frame();
    end else if (idx == REG_HEIGHT) begin
      m_height = val[10:0];
      restart_frame();
    end
    @(negedge clk_i);
  endtask

  task automatic set_frame(int r, int w, int h);
    write_reg(REG_RADIUS, r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  function automatic logic [31:0] rand_pixel();
    if ($urandom_range(0, 1)) return $urandom();
    return palette[$urandom_range(0, 3)];
  endfunction

  // whole frame plus the items needed to drain held-back outputs
  task automatic send_frame(int count);
    for (int i = 0; i < count; i++) send_pixel(rand_pixel());
    while (frame_in_done) send_pixel($urandom());
  endtask

  task automatic test_reset_defaults();
    for (int i = 0; i < 8; i++) send_pixel($urandom());
    wait_idle();
  endtask

  task automatic test_directed();
    set_frame(0, 1, 1);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hFF00_0000);
    send_pixel(32'h00FF_FFFF);
    wait_idle();
    set_frame(7, 3, 2);
    send_pixel(32'h00FF_0000);
    send_pixel(32'h0000_FF00);
    send_pixel(32'h0000_00FF);
    send_pixel(32'h00FF_0000);
    send_pixel(32'h0000_FF00);
    send_pixel(32'h0000_00FF);
    wait_idle();
    write_reg(UNUSED_REG, 11'h7FF);
    set_frame(1, 4, 3);
    for (int i = 0; i < 12; i++) send_pixel((i % 3 == 0) ? 32'h1234_5678 : 32'h8765_4321);
    wait_idle();
  endtask

  task automatic test_burst_drain();
    set_frame(3, 24, 4);
    send_frame(96);
    wait_idle();
  endtask

  task automatic test_size_limits();
    set_frame(1, 2047, 1);
    for (int i = 0; i < 40; i++) send_pixel(rand_pixel());
    wait_idle();
    set_frame(7, 0, 2047);
    for (int i = 0; i < 40; i++) send_pixel(rand_pixel());
    wait_idle();
    set_frame(2, 5, 0);
    send_frame(5);
    wait_idle();
  endtask

  task automatic test_backpressure();
    set_frame(1, 10, 6);
    hold_cycles = 3000;
    send_frame(60);
    wait_idle();
    set_frame(2, 7, 5);
    for (int i = 0; i < 20; i++) send_pixel(rand_pixel());
    pix.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_q.size() != 0) @(negedge clk_i);
    send_frame(15);
    wait_idle();
  endtask

  task automatic test_random(int items);
    int sent, w, h, n;
    sent = 0;
    while (sent < items) begin
      for (int k = 0; k < 4; k++) palette[k] = $urandom();
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 6);
      set_frame($urandom_range(0, 7), w, h);
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, w * h);
        for (int i = 0; i < n; i++) send_pixel(rand_pixel());
      end else begin
        n = w * h;
        send_frame(n);
      end
      sent += n;
      wait_idle();
    end
  endtask

  initial begin
    pix.valid = 1'b0;
    pix.pixel_argb = '0;
    res.ready = 1'b0;
    tb_radius = 3'd2;
    m_width = 11'd640;
    m_height = 11'd480;
    restart_frame();
    for (int k = 0; k < 4; k++) palette[k] = $urandom();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_pct = 14;
    recv_pct = 55;
    test_reset_defaults();
    test_directed();
    test_burst_drain();
    test_size_limits();
    test_backpressure();
    test_random(30);
    send_pct = 55;
    recv_pct = 14;
    test_random(30);
    send_pct = 0;
    recv_pct = 0;
    test_random(30);

    wait_idle();
    if (errors == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
